// ----- hw/rtl/q2e_pkg.sv -----
// Shared widths, constants and the arctangent table of the quaternion-to-Euler pipeline.
`default_nettype none
package q2e_pkg;

    // Parameter defaults
    localparam int DATA_WIDTH_DEF  = 16;
    localparam int CORDIC_ITER_DEF = 16;

    // Internal widths
    localparam int PROD_W = 32;   // one component product, 28 fraction bits
    localparam int SUM_W  = 36;   // doubled product sums, 28 fraction bits
    localparam int MAG_W  = 28;   // magnitude of an unclamped pitch sine
    localparam int RAD_W  = 58;   // radicand 2^56 - s^2, padded to an even width
    localparam int ROOT_W = RAD_W / 2;
    localparam int REM_W  = ROOT_W + 3;
    localparam int CX_W   = 40;   // CORDIC x and y
    localparam int Z_W    = 32;   // angle accumulator, 24 fraction bits
    localparam int ANG_W  = 16;   // output angles, Q2.13

    localparam logic signed [SUM_W-1:0] ONE_Q28     = SUM_W'(64'sd268435456);
    localparam logic signed [Z_W-1:0]   HALF_PI_A24 = Z_W'(64'sd26353589);
    localparam logic signed [Z_W-1:0]   ROUND_A24   = Z_W'(64'sd1024);
    localparam logic signed [Z_W-1:0]   PI_Q13_Z    = Z_W'(64'sd25736);
    localparam logic signed [ANG_W-1:0] PI_Q13      = ANG_W'(64'sd25736);
    localparam logic signed [ANG_W-1:0] HALF_PI_Q13 = ANG_W'(64'sd12868);

    // Operands handed from the front end to the angle units
    typedef struct packed {
        logic                    valid;
        logic signed [SUM_W-1:0] sr;
        logic signed [SUM_W-1:0] cr;
        logic signed [SUM_W-1:0] sp;
        logic signed [SUM_W-1:0] sy;
        logic signed [SUM_W-1:0] cy;
        logic                    clamp;
    } q2e_ops_t;

    // atan(2^-i) with 24 fraction bits
    function automatic logic signed [Z_W-1:0] atan_tab(input int i);
        logic signed [Z_W-1:0] r;
        case (i)
            0:       r = Z_W'(64'sd13176795);
            1:       r = Z_W'(64'sd7778716);
            2:       r = Z_W'(64'sd4110060);
            3:       r = Z_W'(64'sd2086331);
            4:       r = Z_W'(64'sd1047214);
            5:       r = Z_W'(64'sd524117);
            6:       r = Z_W'(64'sd262123);
            7:       r = Z_W'(64'sd131069);
            8:       r = Z_W'(64'sd65536);
            9:       r = Z_W'(64'sd32768);
            10:      r = Z_W'(64'sd16384);
            11:      r = Z_W'(64'sd8192);
            12:      r = Z_W'(64'sd4096);
            13:      r = Z_W'(64'sd2048);
            14:      r = Z_W'(64'sd1024);
            15:      r = Z_W'(64'sd512);
            16:      r = Z_W'(64'sd256);
            17:      r = Z_W'(64'sd128);
            18:      r = Z_W'(64'sd64);
            19:      r = Z_W'(64'sd32);
            20:      r = Z_W'(64'sd16);
            21:      r = Z_W'(64'sd8);
            22:      r = Z_W'(64'sd4);
            23:      r = Z_W'(64'sd2);
            24:      r = Z_W'(64'sd1);
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/q2e_front.sv -----
// Front end: input capture, component products, sine/cosine sums and the pitch radicand.
`default_nettype none
module q2e_front #(
    parameter int DATA_WIDTH = q2e_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic signed [DATA_WIDTH-1:0] qx,
    input  wire logic signed [DATA_WIDTH-1:0] qy,
    input  wire logic signed [DATA_WIDTH-1:0] qz,
    input  wire logic signed [DATA_WIDTH-1:0] qw,
    output q2e_pkg::q2e_ops_t                 ops,
    output logic [q2e_pkg::RAD_W-1:0]         rad
);
    import q2e_pkg::*;

    localparam int SH  = 2 * DATA_WIDTH - 32;
    localparam int SHR = (SH > 0) ? SH : 0;
    localparam int SHL = (SH < 0) ? -SH : 0;

    // Exact product brought to 28 fraction bits
    function automatic logic signed [PROD_W-1:0] mul28(
        input logic signed [DATA_WIDTH-1:0] a,
        input logic signed [DATA_WIDTH-1:0] b
    );
        logic signed [2*DATA_WIDTH-1:0] p;
        logic signed [63:0]             p64;
        p   = a * b;
        p64 = 64'(p);
        return PROD_W'((p64 <<< SHL) >>> SHR);
    endfunction

    logic                         v0_reg, v1_reg;
    logic signed [DATA_WIDTH-1:0] x0_reg, y0_reg, z0_reg, w0_reg;
    logic signed [PROD_W-1:0]     wx_reg, yz_reg, xx_reg, yy_reg;
    logic signed [PROD_W-1:0]     wy_reg, zx_reg, wz_reg, xy_reg, zz_reg;
    q2e_ops_t                     s2_reg, s2_next, s3_reg, s3_next, s4_reg;
    logic [MAG_W-1:0]             mag_reg, mag_next;
    logic [RAD_W-1:0]             rad_reg;
    logic [2*MAG_W-1:0]           sq;

    // Stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
        end
        else
        begin
            v0_reg <= start;
            v1_reg <= v0_reg;
        end
    end

    // Capture inputs and form the products
    always_ff @(posedge clk)
    begin
        x0_reg <= qx;
        y0_reg <= qy;
        z0_reg <= qz;
        w0_reg <= qw;
        wx_reg <= mul28(w0_reg, x0_reg);
        yz_reg <= mul28(y0_reg, z0_reg);
        xx_reg <= mul28(x0_reg, x0_reg);
        yy_reg <= mul28(y0_reg, y0_reg);
        wy_reg <= mul28(w0_reg, y0_reg);
        zx_reg <= mul28(z0_reg, x0_reg);
        wz_reg <= mul28(w0_reg, z0_reg);
        xy_reg <= mul28(x0_reg, y0_reg);
        zz_reg <= mul28(z0_reg, z0_reg);
    end

    // Doubled sums
    always_comb
    begin
        s2_next.valid = v1_reg;
        s2_next.sr    = (SUM_W'(wx_reg) + SUM_W'(yz_reg)) <<< 1;
        s2_next.cr    = ONE_Q28 - ((SUM_W'(xx_reg) + SUM_W'(yy_reg)) <<< 1);
        s2_next.sp    = (SUM_W'(wy_reg) - SUM_W'(zx_reg)) <<< 1;
        s2_next.sy    = (SUM_W'(wz_reg) + SUM_W'(xy_reg)) <<< 1;
        s2_next.cy    = ONE_Q28 - ((SUM_W'(yy_reg) + SUM_W'(zz_reg)) <<< 1);
        s2_next.clamp = 1'b0;
    end

    // Detect a clamped pitch and take the sine magnitude
    always_comb
    begin
        s3_next       = s2_reg;
        s3_next.clamp = (s2_reg.sp >= ONE_Q28) || (s2_reg.sp <= -ONE_Q28);
        if (s3_next.clamp)
            mag_next = '0;
        else if (s2_reg.sp < 0)
            mag_next = MAG_W'(-s2_reg.sp);
        else
            mag_next = MAG_W'(s2_reg.sp);
    end

    assign sq = (2*MAG_W)'(mag_reg) * (2*MAG_W)'(mag_reg);

    // Control part of the struct pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_reg <= '0;
            s3_reg <= '0;
            s4_reg <= '0;
        end
        else
        begin
            s2_reg <= s2_next;
            s3_reg <= s3_next;
            s4_reg <= s3_reg;
        end
    end

    // Square and form the radicand
    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
        rad_reg <= (RAD_W'(1) << (2*MAG_W)) - RAD_W'(sq);
    end

    assign ops = s4_reg;
    assign rad = rad_reg;

endmodule
`default_nettype wire

// ----- hw/rtl/q2e_isqrt.sv -----
// Pipelined integer square root, one result bit per stage.
`default_nettype none
module q2e_isqrt (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    input  wire logic [q2e_pkg::RAD_W-1:0]     rad,
    output logic                               out_valid,
    output logic [q2e_pkg::ROOT_W-1:0]         root
);
    import q2e_pkg::*;

    logic [RAD_W-1:0]  rad_reg  [ROOT_W];
    logic [REM_W-1:0]  rem_reg  [ROOT_W];
    logic [REM_W-1:0]  rem_next [ROOT_W];
    logic [ROOT_W-1:0] root_reg [ROOT_W];
    logic [ROOT_W-1:0] root_next[ROOT_W];
    logic              vld_reg  [ROOT_W];

    // One restoring step per stage
    always_comb
    begin
        logic [RAD_W-1:0]  rad_in;
        logic [REM_W-1:0]  rem_in;
        logic [ROOT_W-1:0] root_in;
        logic [REM_W-1:0]  rp;
        logic [REM_W-1:0]  t;
        for (int k = 0; k < ROOT_W; k++)
        begin
            if (k == 0)
            begin
                rad_in  = rad;
                rem_in  = '0;
                root_in = '0;
            end
            else
            begin
                rad_in  = rad_reg[k-1];
                rem_in  = rem_reg[k-1];
                root_in = root_reg[k-1];
            end
            rp = {rem_in[REM_W-3:0], rad_in[RAD_W-1-2*k -: 2]};
            t  = (REM_W'(root_in) << 2) | REM_W'(1);
            if (rp >= t)
            begin
                rem_next[k]  = rp - t;
                root_next[k] = {root_in[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[k]  = rp;
                root_next[k] = {root_in[ROOT_W-2:0], 1'b0};
            end
        end
    end

    // Advance the valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < ROOT_W; k++)
                vld_reg[k] <= 1'b0;
        end
        else
        begin
            vld_reg[0] <= in_valid;
            for (int k = 1; k < ROOT_W; k++)
                vld_reg[k] <= vld_reg[k-1];
        end
    end

    // Advance the data
    always_ff @(posedge clk)
    begin
        rad_reg[0] <= rad;
        for (int k = 1; k < ROOT_W; k++)
            rad_reg[k] <= rad_reg[k-1];
        for (int k = 0; k < ROOT_W; k++)
        begin
            rem_reg[k]  <= rem_next[k];
            root_reg[k] <= root_next[k];
        end
    end

    assign out_valid = vld_reg[ROOT_W-1];
    assign root      = root_reg[ROOT_W-1];

endmodule
`default_nettype wire

// ----- hw/rtl/q2e_cordic.sv -----
// Pipelined CORDIC vectoring unit giving atan2(y, x) in Q2.13 radians.
`default_nettype none
module q2e_cordic #(
    parameter int CORDIC_ITERATIONS = q2e_pkg::CORDIC_ITER_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    input  wire logic signed [q2e_pkg::CX_W-1:0]    x,
    input  wire logic signed [q2e_pkg::CX_W-1:0]    y,
    output logic                                    out_valid,
    output logic signed [q2e_pkg::ANG_W-1:0]        angle
);
    import q2e_pkg::*;

    localparam int N = CORDIC_ITERATIONS;

    logic signed [CX_W-1:0] x_reg [N+1];
    logic signed [CX_W-1:0] y_reg [N+1];
    logic signed [Z_W-1:0]  z_reg [N+1];
    logic signed [CX_W-1:0] x_next[N+1];
    logic signed [CX_W-1:0] y_next[N+1];
    logic signed [Z_W-1:0]  z_next[N+1];
    logic                   zero_reg[N+1];
    logic                   vld_reg [N+1];
    logic                   ovld_reg;
    logic signed [ANG_W-1:0] angle_reg;
    logic signed [Z_W-1:0]  rounded;

    // Turn a left half-plane vector by a quarter turn, then iterate
    always_comb
    begin
        x_next[0] = x;
        y_next[0] = y;
        z_next[0] = '0;
        if (x < 0)
        begin
            if (y >= 0)
            begin
                x_next[0] = y;
                y_next[0] = -x;
                z_next[0] = HALF_PI_A24;
            end
            else
            begin
                x_next[0] = -y;
                y_next[0] = x;
                z_next[0] = -HALF_PI_A24;
            end
        end
        for (int i = 0; i < N; i++)
        begin
            if (y_reg[i] > 0)
            begin
                x_next[i+1] = x_reg[i] + (y_reg[i] >>> i);
                y_next[i+1] = y_reg[i] - (x_reg[i] >>> i);
                z_next[i+1] = z_reg[i] + atan_tab(i);
            end
            else
            begin
                x_next[i+1] = x_reg[i] - (y_reg[i] >>> i);
                y_next[i+1] = y_reg[i] + (x_reg[i] >>> i);
                z_next[i+1] = z_reg[i] - atan_tab(i);
            end
        end
    end

    assign rounded = (z_reg[N] + ROUND_A24) >>> 11;

    // Advance the valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= N; i++)
                vld_reg[i] <= 1'b0;
            ovld_reg <= 1'b0;
        end
        else
        begin
            vld_reg[0] <= in_valid;
            for (int i = 1; i <= N; i++)
                vld_reg[i] <= vld_reg[i-1];
            ovld_reg <= vld_reg[N];
        end
    end

    // Advance the data; round and saturate at the end
    always_ff @(posedge clk)
    begin
        zero_reg[0] <= (x == 0) && (y == 0);
        for (int i = 1; i <= N; i++)
            zero_reg[i] <= zero_reg[i-1];
        for (int i = 0; i <= N; i++)
        begin
            x_reg[i] <= x_next[i];
            y_reg[i] <= y_next[i];
            z_reg[i] <= z_next[i];
        end
        if (zero_reg[N])
            angle_reg <= '0;
        else if (rounded > PI_Q13_Z)
            angle_reg <= PI_Q13;
        else if (rounded < -PI_Q13_Z)
            angle_reg <= -PI_Q13;
        else
            angle_reg <= ANG_W'(rounded);
    end

    assign out_valid = ovld_reg;
    assign angle     = angle_reg;

endmodule
`default_nettype wire

// ----- hw/rtl/quaternion_to_euler.sv -----
// Top level: quaternion (x, y, z, w) to roll, pitch and yaw.
// A quaternion is taken in every cycle that start is high; busy stays low.
// Each result appears on roll/pitch/yaw/pitch_clamped for one cycle with
// valid high, after the front end, the square root, the CORDIC units and
// the output register. Most of the delay comes from the 29-stage square
// root that feeds the pitch arctangent and from one stage per CORDIC
// iteration; the receiver must take each result in the cycle it appears.
`default_nettype none
module quaternion_to_euler #(
    parameter int DATA_WIDTH        = q2e_pkg::DATA_WIDTH_DEF,
    parameter int CORDIC_ITERATIONS = q2e_pkg::CORDIC_ITER_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               start,
    output logic                                    busy,
    input  wire logic signed [DATA_WIDTH-1:0]       qx,
    input  wire logic signed [DATA_WIDTH-1:0]       qy,
    input  wire logic signed [DATA_WIDTH-1:0]       qz,
    input  wire logic signed [DATA_WIDTH-1:0]       qw,
    output logic                                    valid,
    output logic signed [q2e_pkg::ANG_W-1:0]        roll,
    output logic signed [q2e_pkg::ANG_W-1:0]        pitch,
    output logic signed [q2e_pkg::ANG_W-1:0]        yaw,
    output logic                                    pitch_clamped
);
    import q2e_pkg::*;

    localparam int CL  = CORDIC_ITERATIONS + 2;
    localparam int LAT = 5 + ROOT_W + CL + 1;

    q2e_ops_t                ops;
    logic [RAD_W-1:0]        rad;
    logic                    root_valid;
    logic [ROOT_W-1:0]       root;
    q2e_ops_t                dly_reg[ROOT_W];
    logic                    cl_reg [CL];
    logic                    neg_reg[CL];
    logic                    rv, pv, yv;
    logic signed [ANG_W-1:0] r_ang, p_ang, y_ang;
    logic                    valid_reg;
    logic signed [ANG_W-1:0] roll_reg, pitch_reg, yaw_reg;
    logic                    clamp_reg;
    q2e_ops_t                d;

    assign busy = 1'b0;

    q2e_front #(
        .DATA_WIDTH(DATA_WIDTH)
    ) u_front (
        .clk  (clk),
        .rst_n(rst_n),
        .start(start),
        .qx   (qx),
        .qy   (qy),
        .qz   (qz),
        .qw   (qw),
        .ops  (ops),
        .rad  (rad)
    );

    q2e_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (ops.valid),
        .rad      (rad),
        .out_valid(root_valid),
        .root     (root)
    );

    // Hold the angle operands while the square root runs
    always_ff @(posedge clk)
    begin
        dly_reg[0] <= ops;
        for (int k = 1; k < ROOT_W; k++)
            dly_reg[k] <= dly_reg[k-1];
    end

    assign d = dly_reg[ROOT_W-1];

    q2e_cordic #(
        .CORDIC_ITERATIONS(CORDIC_ITERATIONS)
    ) u_roll (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (root_valid),
        .x        (CX_W'(d.cr)),
        .y        (CX_W'(d.sr)),
        .out_valid(rv),
        .angle    (r_ang)
    );

    q2e_cordic #(
        .CORDIC_ITERATIONS(CORDIC_ITERATIONS)
    ) u_pitch (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (root_valid),
        .x        (signed'(CX_W'(root))),
        .y        (CX_W'(d.sp)),
        .out_valid(pv),
        .angle    (p_ang)
    );

    q2e_cordic #(
        .CORDIC_ITERATIONS(CORDIC_ITERATIONS)
    ) u_yaw (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (root_valid),
        .x        (CX_W'(d.cy)),
        .y        (CX_W'(d.sy)),
        .out_valid(yv),
        .angle    (y_ang)
    );

    // Carry the clamp decision alongside the CORDIC units
    always_ff @(posedge clk)
    begin
        cl_reg[0]  <= d.clamp;
        neg_reg[0] <= d.sp[SUM_W-1];
        for (int k = 1; k < CL; k++)
        begin
            cl_reg[k]  <= cl_reg[k-1];
            neg_reg[k] <= neg_reg[k-1];
        end
    end

    // Output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= rv & pv & yv;
    end

    // Output register; a clamped pitch is a quarter turn with the sine's sign
    always_ff @(posedge clk)
    begin
        roll_reg  <= r_ang;
        yaw_reg   <= y_ang;
        clamp_reg <= cl_reg[CL-1];
        if (cl_reg[CL-1])
            pitch_reg <= neg_reg[CL-1] ? -HALF_PI_Q13 : HALF_PI_Q13;
        else
            pitch_reg <= p_ang;
    end

    assign valid         = valid_reg;
    assign roll          = roll_reg;
    assign pitch         = pitch_reg;
    assign yaw           = yaw_reg;
    assign pitch_clamped = clamp_reg;

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> $past(start, LAT))
        else $error("result without a transfer at the pipeline latency");

    a_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        valid && pitch_clamped |-> (pitch == HALF_PI_Q13 || pitch == -HALF_PI_Q13))
        else $error("clamped pitch is not a quarter turn");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> (roll <= PI_Q13 && roll >= -PI_Q13 && yaw <= PI_Q13 && yaw >= -PI_Q13))
        else $error("angle outside minus pi to pi");

endmodule
`default_nettype wire

// ----- tb/tb_quaternion_to_euler.sv -----
// Self-checking testbench for the quaternion to roll/pitch/yaw pipeline.
`default_nettype none

module tb_quaternion_to_euler;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DW = 16;
    localparam int ITERS = 16;
    localparam int LATENCY = 5 + 29 + ITERS + 3;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_ITEMS = 1250;
    localparam longint ONE28 = 64'sd268435456;
    localparam longint HALF_PI_Z = 64'sd26353589;
    localparam int PI_Q = 25736;
    localparam int HALF_PI_Q = 12868;

    typedef struct {
        logic signed [15:0] roll;
        logic signed [15:0] pitch;
        logic signed [15:0] yaw;
        logic               clamped;
    } angles_t;

    // Shift right with floor for negative values.
    function automatic longint floor_shr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint prod28(longint a, longint b);
        return (a * b) << (28 - 2 * (DW - 2));
    endfunction

    function automatic longint isqrt(longint unsigned n);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return longint'(r);
    endfunction

    function automatic longint atan_step(int i);
        longint tab [25] = '{13176795, 7778716, 4110060, 2086331, 1047214, 524117,
            262123, 131069, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
            256, 128, 64, 32, 16, 8, 4, 2, 1};
        return (i < 25) ? tab[i] : 0;
    endfunction

    function automatic longint vector_angle(longint y, longint x);
        longint z, t, dx, dy;
        z = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0)
        begin
            t = x;
            if (y >= 0)
            begin
                x = y; y = -t; z = HALF_PI_Z;
            end
            else
            begin
                x = -y; y = t; z = -HALF_PI_Z;
            end
        end
        for (int i = 0; i < ITERS; i++)
        begin
            dx = floor_shr(y, i);
            dy = floor_shr(x, i);
            if (y > 0)
            begin
                x += dx; y -= dy; z += atan_step(i);
            end
            else
            begin
                x -= dx; y += dy; z -= atan_step(i);
            end
        end
        return z;
    endfunction

    function automatic logic signed [15:0] angle_q13(longint z);
        longint r;
        r = floor_shr(z + 1024, 11);
        if (r > PI_Q) r = PI_Q;
        if (r < -PI_Q) r = -PI_Q;
        return 16'(r);
    endfunction

    function automatic angles_t euler_of(longint x, longint y, longint z, longint w);
        angles_t a;
        longint sr, cr, sp, sy, cy, mag;
        sr = 2 * (prod28(w, x) + prod28(y, z));
        cr = ONE28 - 2 * (prod28(x, x) + prod28(y, y));
        a.roll = angle_q13(vector_angle(sr, cr));
        sp = 2 * (prod28(w, y) - prod28(z, x));
        a.clamped = (sp >= ONE28 || sp <= -ONE28);
        if (a.clamped)
            a.pitch = sp > 0 ? 16'(HALF_PI_Q) : -16'(HALF_PI_Q);
        else
        begin
            mag = sp < 0 ? -sp : sp;
            a.pitch = angle_q13(vector_angle(sp, isqrt((64'd1 << 56) - mag * mag)));
        end
        sy = 2 * (prod28(w, z) + prod28(x, y));
        cy = ONE28 - 2 * (prod28(y, y) + prod28(z, z));
        a.yaw = angle_q13(vector_angle(sy, cy));
        return a;
    endfunction

    class angle_scoreboard;
        angles_t pending[$];
        int errors;

        function void note_quaternion(longint x, longint y, longint z, longint w);
            pending.push_back(euler_of(x, y, z, w));
        endfunction

        function void check_angles(angles_t got);
            angles_t exp;
            if (pending.size() == 0)
            begin
                $error("unexpected result roll=%0d pitch=%0d yaw=%0d",
                    got.roll, got.pitch, got.yaw);
                errors++;
                return;
            end
            exp = pending.pop_front();
            if (got.roll !== exp.roll)
            begin
                $error("roll: expected %0d, got %0d", exp.roll, got.roll);
                errors++;
            end
            if (got.pitch !== exp.pitch)
            begin
                $error("pitch: expected %0d, got %0d", exp.pitch, got.pitch);
                errors++;
            end
            if (got.yaw !== exp.yaw)
            begin
                $error("yaw: expected %0d, got %0d", exp.yaw, got.yaw);
                errors++;
            end
            if (got.clamped !== exp.clamped)
            begin
                $error("pitch_clamped: expected %0b, got %0b", exp.clamped, got.clamped);
                errors++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy, valid, pitch_clamped;
    logic signed [DW-1:0] qx = '0, qy = '0, qz = '0, qw = '0;
    logic signed [15:0] roll, pitch, yaw;
    int cycles = 0;
    angle_scoreboard sb = new();

    quaternion_to_euler dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .qx(qx), .qy(qy), .qz(qz), .qw(qw),
        .valid(valid), .roll(roll), .pitch(pitch), .yaw(yaw),
        .pitch_clamped(pitch_clamped)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Check each result on the edge that ends its cycle.
    always @(posedge clk)
    begin
        angles_t got;
        cycles <= cycles + 1;
        if (rst_n && valid)
        begin
            got.roll = roll;
            got.pitch = pitch;
            got.yaw = yaw;
            got.clamped = pitch_clamped;
            sb.check_angles(got);
        end
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Present one quaternion and hold it until the transfer.
    task automatic send_quaternion(logic [15:0] x, logic [15:0] y, logic [15:0] z,
            logic [15:0] w, int gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        qx <= x; qy <= y; qz <= z; qw <= w;
        do @(posedge clk); while (busy);
        sb.note_quaternion($signed(x), $signed(y), $signed(z), $signed(w));
    endtask

    // Random near-unit quaternion, with sign flips and small jitter.
    task automatic send_unit(int gap);
        int a, b, c, d;
        longint n;
        a = $urandom_range(0, 16384); b = $urandom_range(0, 16384);
        c = $urandom_range(0, 16384); d = $urandom_range(0, 16384);
        n = longint'(a) * a + longint'(b) * b + longint'(c) * c + longint'(d) * d;
        if (n == 0)
        begin
            a = 16384;
            n = longint'(a) * a;
        end
        a = int'(a * 16384.0 / $sqrt(real'(n)));
        b = int'(b * 16384.0 / $sqrt(real'(n)));
        c = int'(c * 16384.0 / $sqrt(real'(n)));
        d = int'(d * 16384.0 / $sqrt(real'(n)));
        if ($urandom_range(0, 1)) a = -a;
        if ($urandom_range(0, 1)) b = -b;
        if ($urandom_range(0, 1)) c = -c;
        if ($urandom_range(0, 1)) d = -d;
        send_quaternion(16'(a + int'($urandom_range(0, 4)) - 2),
            16'(b + int'($urandom_range(0, 4)) - 2),
            16'(c), 16'(d), gap);
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: identity, axis turns, pitch near gimbal lock both ways, a clamped pitch, extremes, zero.
        send_quaternion(16'sd0, 16'sd0, 16'sd0, 16'sd16384, 0);
        send_quaternion(16'sd16384, 16'sd0, 16'sd0, 16'sd0, 0);
        send_quaternion(16'sd0, 16'sd16384, 16'sd0, 16'sd0, 0);
        send_quaternion(16'sd0, 16'sd0, 16'sd16384, 16'sd0, 0);
        send_quaternion(16'sd0, 16'sd11585, 16'sd0, 16'sd11585, 0);
        send_quaternion(16'sd0, -16'sd11585, 16'sd0, 16'sd11585, 1);
        send_quaternion(16'sd0, 16'sd11586, 16'sd0, 16'sd11586, 0);
        send_quaternion(16'sd11585, 16'sd0, 16'sd0, 16'sd11585, 0);
        send_quaternion(16'sd0, 16'sd0, 16'sd11585, -16'sd11585, 2);
        send_quaternion(16'sd0, 16'sd0, 16'sd0, 16'sd0, 0);
        send_quaternion(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 0);
        send_quaternion(16'h8000, 16'h8000, 16'h8000, 16'h8000, 0);
        send_quaternion(16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 0);
        send_quaternion(16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 5);
        send_quaternion(16'sd1, -16'sd1, 16'sd1, -16'sd1, 0);
        send_quaternion(16'sd8192, 16'sd8192, 16'sd8192, 16'sd8192, 0);
        send_quaternion(-16'sd8192, 16'sd8192, 16'sd8192, 16'sd8192, 0);
        send_quaternion(16'sd0, 16'sd0, 16'sd0, -16'sd16384, 0);

        // Random: mostly near-unit quaternions, the rest raw bit patterns.
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % 200 < 40)
            begin
                if ($urandom_range(0, 3) == 0)
                    send_quaternion(16'($urandom), 16'($urandom), 16'($urandom),
                        16'($urandom), 0);
                else
                    send_unit(0);
            end
            else if ($urandom_range(0, 3) == 0)
                send_quaternion(16'($urandom), 16'($urandom), 16'($urandom),
                    16'($urandom), gap_len());
            else
                send_unit(gap_len());
        end
        start <= 1'b0;

        // Drain the pipeline, then linger a little.
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
        if (sb.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule

`default_nettype wire
